[src/agmc_pkg.sv]
package agmc_pkg;

  localparam int MAX_COMPONENTS = 8;
  localparam int NUM_CH         = 3;
  localparam int NUM_WORDS      = 10;
  localparam int COMP_W         = 3;
  localparam int SCORE_W        = 48;
  localparam int K_W            = 4;
  localparam int CFG_ADDR_W     = 1;
  localparam int CFG_DATA_W     = 4;
  localparam int S_TDATA_W      = 88;
  localparam int S_TUSER_W      = 3;
  localparam int M_TDATA_W      = 56;

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  localparam logic [1:0] MODEL_BG = 2'd0;
  localparam logic [1:0] MODEL_FG = 2'd1;

  localparam logic [3:0] PARAM_MEAN   = 4'd0;
  localparam logic [3:0] PARAM_LEFT   = 4'd3;
  localparam logic [3:0] PARAM_RIGHT  = 4'd6;
  localparam logic [3:0] PARAM_LOG    = 4'd9;
  localparam logic [3:0] PARAM_ACTIVE = 4'd10;

  localparam logic [CFG_ADDR_W-1:0] REG_K_BG = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_K_FG = 1'd1;

  localparam logic [K_W-1:0] K_RESET = 4'd5;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } st_t;

  typedef struct packed {
    logic               vld;
    logic               model;
    logic [K_W-1:0]     k;
    logic [14:0]        light;
    logic signed [15:0] chan_a;
    logic signed [15:0] chan_b;
  } tok_t;

  typedef struct packed {
    logic        vld;
    logic        model;
    logic [2:0]  comp;
    logic [3:0]  param;
    logic [31:0] value;
  } wr_t;

  typedef struct packed {
    logic                      vld;
    logic                      any;
    logic [COMP_W-1:0]         idx;
    logic signed [SCORE_W-1:0] score;
  } best_t;

endpackage

[src/asym_gaussian_mixture_classifier_unit.sv]
// Asymmetric Gaussian mixture classifier. Load transfers (tuser cmd 0) write one table word
// of a background or foreground component and are taken one per cycle while the block is
// idle and no result waits in the holding slot. A classify transfer (tuser cmd 1) for model
// 0 or 1 sends the pixel down a row of MaxComp cells, one cell per cycle; each cell holds one
// component of both tables, scores the pixel in a seven-stage pipeline and passes the running
// best to the next cell. The result is registered into the output slot, and no new transfer
// is taken until the pixel has left the last cell. A classify for an unlabelled model gives
// no result. Two output slots let the next pixel be taken while a result waits. Write
// k_background and k_foreground only while the block is idle.
module asym_gaussian_mixture_classifier_unit
  import agmc_pkg::*;
#(
  parameter int MaxComp = MAX_COMPONENTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // comp, param, value, light, chan_a, chan_b, zero padding
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // cmd, model
  input  logic [S_TUSER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // component, best_score, any_active, zero padding
  output logic [M_TDATA_W-1:0]  m_tdata
);

  logic [K_W-1:0] k_bg;
  logic [K_W-1:0] k_fg;

  st_t  state;
  st_t  state_next;
  logic in_xfer;
  logic launch;
  logic load_ok;
  logic model_ok;
  logic done;
  logic hold_vld;

  logic        in_cmd;
  logic [1:0]  in_model;
  logic [2:0]  in_comp;
  logic [3:0]  in_param;

  tok_t  tok;
  wr_t   wr;
  tok_t  tok_w  [MaxComp + 1];
  best_t best_w [MaxComp + 1];

  assign in_cmd   = s_tuser[0];
  assign in_model = s_tuser[2:1];
  assign in_comp  = s_tdata[2:0];
  assign in_param = s_tdata[6:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      k_bg <= K_RESET;
      k_fg <= K_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_K_BG: k_bg <= cfg_wdata;
        REG_K_FG: k_fg <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_xfer  = s_tvalid && s_tready;
  assign model_ok = (in_model == MODEL_BG) || (in_model == MODEL_FG);
  assign launch   = in_xfer && in_cmd == CMD_CLASSIFY && model_ok;
  assign load_ok  = in_xfer && in_cmd == CMD_LOAD && model_ok
                    && int'(in_comp) < MaxComp && in_param <= PARAM_ACTIVE;
  assign done     = best_w[MaxComp].vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (launch) state_next = ST_RUN;
      ST_RUN:  if (done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE: s_tready = !hold_vld;
      ST_RUN:  s_tready = 1'b0;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.vld <= 1'b0;
      wr.vld  <= 1'b0;
    end else begin
      tok.vld <= launch;
      wr.vld  <= load_ok;
    end
    if (launch) begin
      tok.model  <= in_model[0];
      tok.k      <= (in_model == MODEL_FG) ? k_fg : k_bg;
      tok.light  <= s_tdata[53:39];
      tok.chan_a <= s_tdata[69:54];
      tok.chan_b <= s_tdata[85:70];
    end
    if (load_ok) begin
      wr.model <= in_model[0];
      wr.comp  <= in_comp;
      wr.param <= in_param;
      wr.value <= s_tdata[38:7];
    end
  end

  assign tok_w[0]  = tok;
  assign best_w[0] = '{vld: 1'b0, any: 1'b0, idx: '0, score: '0};

  for (genvar i = 0; i < MaxComp; i++) begin : g_cell
    agmc_cell #(
      .Idx(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .wr     (wr),
      .tok_i  (tok_w[i]),
      .tok_o  (tok_w[i+1]),
      .best_i (best_w[i]),
      .best_o (best_w[i+1])
    );
  end

  agmc_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res      (best_w[MaxComp]),
    .hold_vld (hold_vld),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_launch_run: assert property (@(posedge clk) disable iff (rst)
    launch |=> state == ST_RUN)
    else $error("classify taken without entering run");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_RUN)
    else $error("result left the cell row outside run");

  a_tok_in_run: assert property (@(posedge clk) disable iff (rst)
    tok.vld |-> state == ST_RUN && !s_tready)
    else $error("pixel entered the cell row while input open");

endmodule

[src/agmc_cell.sv]
module agmc_cell
  import agmc_pkg::*;
#(
  parameter int Idx = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  wr_t   wr,
  input  tok_t  tok_i,
  output tok_t  tok_o,
  input  best_t best_i,
  output best_t best_o
);

  logic signed [31:0] wrd [2][NUM_WORDS];
  logic [1:0]         active;

  tok_t tok_q;
  logic [6:1] vs;

  logic signed [16:0] px    [NUM_CH];
  logic signed [32:0] off   [NUM_CH];
  logic signed [31:0] csel  [NUM_CH];
  logic [32:0]        mag0  [NUM_CH];
  logic [23:0]        mag_c [NUM_CH];
  logic [30:0]        coef_c[NUM_CH];

  logic [23:0] mag1  [NUM_CH];
  logic [30:0] coef1 [NUM_CH];
  logic [47:0] sq2   [NUM_CH];
  logic [30:0] coef2 [NUM_CH];
  logic [54:0] phi3  [NUM_CH];
  logic [54:0] plo3  [NUM_CH];
  logic [63:0] tsum  [NUM_CH];
  logic [48:0] term4 [NUM_CH];
  logic [49:0] sum5;
  logic signed [51:0] diff;
  logic signed [SCORE_W-1:0] score6;

  logic  part;
  logic  take;
  logic  best_vld;
  best_t best_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (wr.vld && int'(wr.comp) == Idx && wr.param == PARAM_ACTIVE) begin
      active[wr.model] <= wr.value[0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.vld && int'(wr.comp) == Idx && wr.param != PARAM_ACTIVE) begin
      wrd[wr.model][wr.param] <= wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q <= '0;
      vs    <= '0;
    end else begin
      tok_q <= tok_i;
      vs    <= {vs[5:1], tok_q.vld};
    end
  end

  assign tok_o = tok_q;

  always_comb begin
    px[0] = {2'b00, tok_q.light};
    px[1] = 17'(tok_q.chan_a);
    px[2] = 17'(tok_q.chan_b);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      off[ch]    = 33'(px[ch]) - 33'(wrd[tok_q.model][PARAM_MEAN + 4'(ch)]);
      csel[ch]   = off[ch][32] ? wrd[tok_q.model][PARAM_LEFT + 4'(ch)]
                               : wrd[tok_q.model][PARAM_RIGHT + 4'(ch)];
      coef_c[ch] = csel[ch][31] ? '0 : csel[ch][30:0];
      mag0[ch]   = off[ch][32] ? 33'(-off[ch]) : 33'(off[ch]);
      mag_c[ch]  = (mag0[ch] > 33'h0FF_FFFF) ? 24'hFF_FFFF : mag0[ch][23:0];
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      tsum[ch] = {1'b0, phi3[ch], 8'h00} + {25'd0, plo3[ch][54:16]};
    end
    diff = 52'(wrd[tok_q.model][PARAM_LOG]) - $signed({2'b00, sum5});
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      mag1[ch]  <= mag_c[ch];
      coef1[ch] <= coef_c[ch];
      sq2[ch]   <= mag1[ch] * mag1[ch];
      coef2[ch] <= coef1[ch];
      phi3[ch]  <= coef2[ch] * sq2[ch][47:24];
      plo3[ch]  <= coef2[ch] * sq2[ch][23:0];
      term4[ch] <= (tsum[ch] > 64'h0001_0000_0000_0000) ? 49'h1_0000_0000_0000
                                                        : tsum[ch][48:0];
    end
    sum5 <= 50'(term4[0]) + 50'(term4[1]) + 50'(term4[2]);
    if (diff[51:47] != {5{diff[47]}}) begin
      score6 <= {1'b1, {(SCORE_W - 1){1'b0}}};
    end else begin
      score6 <= diff[SCORE_W-1:0];
    end
  end

  assign part = active[tok_q.model] && (Idx < int'(tok_q.k));
  assign take = part && (!best_i.any || score6 > best_i.score);

  always_ff @(posedge clk) begin
    if (rst) begin
      best_vld <= 1'b0;
    end else begin
      best_vld <= vs[6];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_pay.any   <= 1'b1;
      best_pay.idx   <= COMP_W'(Idx);
      best_pay.score <= score6;
    end else begin
      best_pay.any   <= best_i.any;
      best_pay.idx   <= best_i.idx;
      best_pay.score <= best_i.score;
    end
    best_pay.vld <= 1'b0;
  end

  always_comb begin
    best_o     = best_pay;
    best_o.vld = best_vld;
  end

endmodule

[src/agmc_outq.sv]
module agmc_outq
  import agmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  best_t                res,
  output logic                 hold_vld,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata
);

  logic [M_TDATA_W-1:0] res_data;
  logic [M_TDATA_W-1:0] hold_data;

  assign res_data = {{(M_TDATA_W - COMP_W - SCORE_W - 1){1'b0}},
                     res.any, res.score, res.idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      hold_vld <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (hold_vld) begin
        m_tvalid <= 1'b1;
        hold_vld <= res.vld;
      end else begin
        m_tvalid <= res.vld;
        hold_vld <= 1'b0;
      end
    end else if (res.vld) begin
      hold_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (hold_vld) begin
        m_tdata   <= hold_data;
        hold_data <= res_data;
      end else begin
        m_tdata <= res_data;
      end
    end else if (res.vld) begin
      hold_data <= res_data;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res.vld && m_tvalid && !m_tready |-> !hold_vld)
    else $error("result arrived with both output slots full");

  a_hold_order: assert property (@(posedge clk) disable iff (rst)
    hold_vld |-> m_tvalid)
    else $error("holding slot filled while output slot empty");

endmodule

[verif/tb_asym_gaussian_mixture_classifier_unit.sv]
`timescale 1ns / 1ps

module tb_asym_gaussian_mixture_classifier_unit;
  import agmc_pkg::*;

  localparam logic [1:0] MODEL_UNLABELLED = 2'd2;
  localparam logic [1:0] MODEL_INVALID    = 2'd3;
  localparam logic [3:0] PARAM_LAST       = 4'hF;

  localparam int NUM_PHASES       = 7;
  localparam int ITEMS_PER_PHASE  = 100;
  localparam int DRAIN_CYCLES     = 2 * (MAX_COMPONENTS + 9);
  localparam int LONG_HOLD_CYCLES = 400;

  localparam logic [K_W-1:0] BG_COUNTS [NUM_PHASES] =
    '{K_RESET, 4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8};
  localparam logic [K_W-1:0] FG_COUNTS [NUM_PHASES] =
    '{K_RESET, 4'd8, 4'd8, 4'd15, 4'd0, 4'd7, 4'd1};

  localparam longint unsigned OFFSET_LIMIT = 64'hFF_FFFF;
  localparam longint unsigned TERM_LIMIT   = 64'h1_0000_0000_0000;
  localparam longint          SCORE_FLOOR  = -(64'sd1 <<< 47);

  typedef struct packed {
    logic        cmd;
    logic [1:0]  model;
    logic [2:0]  comp;
    logic [3:0]  param;
    logic [31:0] value;
    logic [14:0] light;
    logic [15:0] chan_a;
    logic [15:0] chan_b;
  } gmm_item_t;

  typedef struct packed {
    logic [COMP_W-1:0]  component;
    logic [SCORE_W-1:0] best_score;
    logic               any_active;
  } assignment_t;

  class gmm_assignment_board;
    logic [31:0]    words [2][MAX_COMPONENTS][NUM_WORDS];
    bit             active [2][MAX_COMPONENTS];
    logic [K_W-1:0] comp_count [2];
    assignment_t    pending_assignments [$];
    int             mismatches;
    int             checked;

    function new();
      for (int m = 0; m < 2; m++) begin
        for (int c = 0; c < MAX_COMPONENTS; c++) begin
          active[m][c] = 1'b0;
          for (int w = 0; w < NUM_WORDS; w++) words[m][c][w] = '0;
        end
      end
      comp_count[0] = K_RESET;
      comp_count[1] = K_RESET;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_count(logic [CFG_ADDR_W-1:0] idx, logic [K_W-1:0] val);
      case (idx)
        REG_K_BG: comp_count[0] = val;
        REG_K_FG: comp_count[1] = val;
        default: ;
      endcase
    endfunction

    function longint unsigned side_cost(longint offset, logic signed [31:0] coef);
      longint unsigned magnitude;
      logic [23:0]     mag;
      logic [47:0]     sq;
      logic [79:0]     prod;
      longint unsigned cost;
      if (coef <= 0) return 0;
      magnitude = (offset < 0) ? -offset : offset;
      mag = (magnitude > OFFSET_LIMIT) ? OFFSET_LIMIT[23:0] : magnitude[23:0];
      sq = mag * mag;
      prod = sq * coef[30:0];
      cost = prod[79:16];
      return (cost > TERM_LIMIT) ? TERM_LIMIT : cost;
    endfunction

    function longint component_score(int m, int c, gmm_item_t it);
      longint          px [NUM_CH];
      longint          offset;
      longint unsigned total;
      longint          s;
      px[0] = longint'(it.light);
      px[1] = longint'($signed(it.chan_a));
      px[2] = longint'($signed(it.chan_b));
      total = 0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        offset = px[ch] - longint'($signed(words[m][c][PARAM_MEAN + ch]));
        total += side_cost(offset, (offset < 0) ? words[m][c][PARAM_LEFT + ch]
                                                : words[m][c][PARAM_RIGHT + ch]);
      end
      s = longint'($signed(words[m][c][PARAM_LOG])) - longint'(total);
      return (s < SCORE_FLOOR) ? SCORE_FLOOR : s;
    endfunction

    function void note_input(gmm_item_t it);
      int          m;
      int          scan;
      longint      s;
      longint      best_s;
      assignment_t res;
      if (it.model != MODEL_BG && it.model != MODEL_FG) return;
      m = (it.model == MODEL_FG) ? 1 : 0;
      if (it.cmd == CMD_LOAD) begin
        if (it.param == PARAM_ACTIVE) active[m][it.comp] = it.value[0];
        else if (it.param < PARAM_ACTIVE) words[m][it.comp][it.param] = it.value;
        return;
      end
      scan = (comp_count[m] > MAX_COMPONENTS) ? MAX_COMPONENTS : comp_count[m];
      res = '0;
      best_s = 0;
      for (int c = 0; c < scan; c++) begin
        if (!active[m][c]) continue;
        s = component_score(m, c, it);
        if (!res.any_active || s > best_s) begin
          res.component = COMP_W'(c);
          res.any_active = 1'b1;
          best_s = s;
        end
      end
      if (res.any_active) res.best_score = best_s[SCORE_W-1:0];
      pending_assignments.insert(pending_assignments.size(), res);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] data);
      assignment_t        want;
      logic [COMP_W-1:0]  got_comp;
      logic [SCORE_W-1:0] got_score;
      logic               got_any;
      got_comp = data[COMP_W-1:0];
      got_score = data[COMP_W +: SCORE_W];
      got_any = data[COMP_W + SCORE_W];
      if (pending_assignments.size() == 0) begin
        $error("unexpected result: component %0d best_score %0d any_active %0d",
               got_comp, $signed(got_score), got_any);
        mismatches++;
        return;
      end
      want = pending_assignments.pop_front();
      checked++;
      if (got_comp !== want.component) begin
        $error("component: expected %0d, actual %0d", want.component, got_comp);
        mismatches++;
      end
      if (got_score !== want.best_score) begin
        $error("best_score: expected %0d, actual %0d",
               $signed(want.best_score), $signed(got_score));
        mismatches++;
      end
      if (got_any !== want.any_active) begin
        $error("any_active: expected %0d, actual %0d", want.any_active, got_any);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [S_TUSER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;

  gmm_assignment_board board = new();

  gmm_item_t   item_queue [$];
  bit          written [2][MAX_COMPONENTS][NUM_WORDS];
  logic [31:0] planned_words [2][MAX_COMPONENTS][NUM_WORDS] = '{default: '0};
  logic [31:0] tie_words [NUM_WORDS];
  int          planned_items = 0;
  int          accepted_items = 0;
  int          holds_wanted = 0;
  bit          offer_pending = 1'b0;

  asym_gaussian_mixture_classifier_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  function automatic bit fully_written(int m, int c);
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (!written[m][c][w]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic gmm_item_t noise_item(logic cmd, logic [1:0] model);
    gmm_item_t it;
    it.cmd = cmd;
    it.model = model;
    it.comp = 3'($urandom_range(0, MAX_COMPONENTS - 1));
    it.param = 4'($urandom_range(0, PARAM_LAST));
    it.value = $urandom;
    it.light = 15'($urandom);
    it.chan_a = 16'($urandom);
    it.chan_b = 16'($urandom);
    return it;
  endfunction

  function automatic gmm_item_t load_item(logic [1:0] model, logic [2:0] comp,
                                          logic [3:0] param, logic [31:0] value);
    gmm_item_t it;
    it = noise_item(CMD_LOAD, model);
    it.comp = comp;
    it.param = param;
    it.value = value;
    return it;
  endfunction

  // An activation is cleared to zero unless every word of the component has been loaded.
  function automatic void push_item(gmm_item_t it);
    int m;
    bit labelled;
    labelled = (it.model == MODEL_BG || it.model == MODEL_FG);
    m = (it.model == MODEL_FG) ? 1 : 0;
    if (labelled && it.cmd == CMD_LOAD) begin
      if (it.param < PARAM_ACTIVE) begin
        written[m][it.comp][it.param] = 1'b1;
        planned_words[m][it.comp][it.param] = it.value;
      end else if (it.param == PARAM_ACTIVE && !fully_written(m, it.comp)) begin
        it.value[0] = 1'b0;
      end
    end
    if (labelled && (it.cmd == CMD_CLASSIFY || it.param <= PARAM_ACTIVE)) planned_items++;
    item_queue.insert(item_queue.size(), it);
  endfunction

  function automatic logic [31:0] table_word(int w);
    int          r;
    logic [15:0] h;
    r = $urandom_range(0, 99);
    h = 16'($urandom);
    if (w < PARAM_LEFT) return (r < 85) ? {{16{h[15]}}, h} : $urandom;
    if (w < PARAM_LOG) begin
      if (r < 70) return $urandom_range(0, 1 << 18);
      if (r < 85) return $urandom;
      if (r < 92) return {1'b1, 31'($urandom)};
      return '0;
    end
    return (r < 80) ? 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24) : $urandom;
  endfunction

  function automatic int jitter(int spread);
    if (spread == 0) return 0;
    return int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  function automatic gmm_item_t pixel_item(logic [1:0] model, int spread);
    gmm_item_t it;
    int        m;
    int        c;
    it = noise_item(CMD_CLASSIFY, model);
    if (spread >= 0) begin
      m = (model == MODEL_FG) ? 1 : 0;
      c = $urandom_range(0, MAX_COMPONENTS - 1);
      it.light = planned_words[m][c][PARAM_MEAN][14:0] + 15'(jitter(spread));
      it.chan_a = planned_words[m][c][PARAM_MEAN + 1][15:0] + 16'(jitter(spread));
      it.chan_b = planned_words[m][c][PARAM_MEAN + 2][15:0] + 16'(jitter(spread));
    end
    return it;
  endfunction

  function automatic void plan_component(logic [1:0] model, logic [2:0] comp, bit copy_tie);
    for (int w = 0; w < NUM_WORDS; w++) begin
      push_item(load_item(model, comp, 4'(w), copy_tie ? tie_words[w] : table_word(w)));
    end
    push_item(load_item(model, comp, PARAM_ACTIVE, $urandom | 32'd1));
  endfunction

  function automatic void plan_directed();
    gmm_item_t it;
    push_item(pixel_item(MODEL_BG, -1));
    push_item(pixel_item(MODEL_FG, -1));
    push_item(noise_item(CMD_CLASSIFY, MODEL_UNLABELLED));
    push_item(noise_item(CMD_CLASSIFY, MODEL_INVALID));
    push_item(load_item(MODEL_INVALID, 3'd7, PARAM_ACTIVE, 32'hFFFF_FFFF));
    push_item(load_item(MODEL_BG, 3'd0, PARAM_LAST, 32'hFFFF_FFFF));
    // Extreme means force saturated offsets; one left coefficient is negative.
    push_item(load_item(MODEL_BG, 3'd0, PARAM_MEAN, 32'h7FFF_FFFF));
    push_item(load_item(MODEL_BG, 3'd0, PARAM_MEAN + 4'd1, 32'h8000_0000));
    push_item(load_item(MODEL_BG, 3'd0, PARAM_MEAN + 4'd2, 32'h0000_0000));
    push_item(load_item(MODEL_BG, 3'd0, PARAM_LEFT, 32'h7FFF_FFFF));
    push_item(load_item(MODEL_BG, 3'd0, PARAM_LEFT + 4'd1, 32'h7FFF_FFFF));
    push_item(load_item(MODEL_BG, 3'd0, PARAM_LEFT + 4'd2, 32'h8000_0000));
    push_item(load_item(MODEL_BG, 3'd0, PARAM_RIGHT, 32'h0000_0000));
    push_item(load_item(MODEL_BG, 3'd0, PARAM_RIGHT + 4'd1, 32'h7FFF_FFFF));
    push_item(load_item(MODEL_BG, 3'd0, PARAM_RIGHT + 4'd2, 32'h0000_0001));
    push_item(load_item(MODEL_BG, 3'd0, PARAM_LOG, 32'h8000_0000));
    push_item(load_item(MODEL_BG, 3'd0, PARAM_ACTIVE, 32'hFFFF_FFFF));
    it = pixel_item(MODEL_BG, -1);
    it.light = '0;
    it.chan_a = 16'h7FFF;
    it.chan_b = 16'h8000;
    push_item(it);
    it = pixel_item(MODEL_BG, -1);
    it.light = 15'h7FFF;
    it.chan_a = 16'h8000;
    it.chan_b = 16'h7FFF;
    push_item(it);
  endfunction

  function automatic void plan_random(int target);
    int         goal;
    int         r;
    int         w;
    logic [1:0] model;
    logic [2:0] comp;
    goal = planned_items + target;
    for (int i = 0; i < NUM_WORDS; i++) tie_words[i] = table_word(i);
    while (planned_items < goal) begin
      r = $urandom_range(0, 99);
      model = $urandom_range(0, 1) ? MODEL_FG : MODEL_BG;
      comp = 3'($urandom_range(0, MAX_COMPONENTS - 1));
      w = $urandom_range(0, NUM_WORDS - 1);
      if (r < 45) begin
        push_item(pixel_item(model, ($urandom_range(0, 2) == 0) ? -1 :
                                    ($urandom_range(0, 1) ? 64 : 4096)));
      end else if (r < 53) begin
        push_item(pixel_item(model, 0));
      end else if (r < 61) begin
        plan_component(model, comp, $urandom_range(0, 3) == 0);
      end else if (r < 71) begin
        push_item(load_item(model, comp, 4'(w), table_word(w)));
      end else if (r < 77) begin
        push_item(load_item(model, comp, PARAM_ACTIVE, $urandom));
      end else if (r < 85) begin
        if ($urandom_range(0, 1)) begin
          push_item(noise_item(CMD_LOAD, 2'($urandom_range(MODEL_UNLABELLED, MODEL_INVALID))));
        end else begin
          push_item(load_item(model, comp, 4'($urandom_range(PARAM_ACTIVE + 1, PARAM_LAST)),
                              $urandom));
        end
      end else begin
        push_item(noise_item(CMD_CLASSIFY, 2'($urandom_range(MODEL_UNLABELLED, MODEL_INVALID))));
      end
    end
  endfunction

  task automatic write_count(logic [CFG_ADDR_W-1:0] idx, logic [K_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    board.set_count(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (item_queue.size() != 0 || offer_pending || board.pending_assignments.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : item_source
    gmm_item_t offered;
    int        burst_left;
    int        gap_left;
    burst_left = 0;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (s_tvalid && s_tready) begin
        board.note_input(offered);
        accepted_items++;
        offer_pending = 1'b0;
      end
      if (!offer_pending) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (item_queue.size() != 0) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 40);
          offered = item_queue.pop_front();
          s_tdata <= S_TDATA_W'({offered.chan_b, offered.chan_a, offered.light,
                                 offered.value, offered.param, offered.comp});
          s_tuser <= {offered.model, offered.cmd};
          s_tvalid <= 1'b1;
          offer_pending = 1'b1;
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  initial begin : result_sink
    int run_left;
    bit run_ready;
    int hold_left;
    int holds_done;
    run_left = 0;
    run_ready = 1'b0;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) board.check_result(m_tdata);
      if (holds_done < holds_wanted) begin
        hold_left = LONG_HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_ready = !run_ready;
          if (run_ready) run_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
          else run_left = $urandom_range(1, 5);
        end
        run_left--;
        m_tready <= run_ready;
      end
    end
  end

  initial begin : run_phases
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        write_count(REG_K_BG, BG_COUNTS[p]);
        write_count(REG_K_FG, FG_COUNTS[p]);
      end
      if (p == 0) plan_directed();
      plan_random(ITEMS_PER_PHASE);
      if (p == 2 || p == 5) holds_wanted++;
      wait_drained();
    end
    if (board.pending_assignments.size() != 0) begin
      $error("%0d expected assignments never arrived", board.pending_assignments.size());
      board.mismatches++;
    end
    $display("Accepted %0d transfers and checked %0d assignments over %0d count settings,",
             accepted_items, board.checked, NUM_PHASES);
    $display("including empty, single, full and over-range component scans.");
    if (board.mismatches == 0) begin
      $display("asym_gaussian_mixture_classifier_unit regression: pass");
    end else begin
      $display("asym_gaussian_mixture_classifier_unit regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("asym_gaussian_mixture_classifier_unit regression: fail");
    $finish;
  end

endmodule
